// File: hw/rtl/bdkm_pkg.sv
// Shared constants for the keyboard base detect and key matrix block.
`default_nettype none
package bdkm_pkg;

  localparam int unsigned NUM_COLS_DEF = 16;

  localparam logic [11:0] ATTACH_RESET_MV = 12'd300;
  localparam logic [11:0] DETACH_RESET_MV = 12'd3000;

  localparam logic [2:0] ACT_TICK         = 3'd0;
  localparam logic [2:0] ACT_COLUMN       = 3'd1;
  localparam logic [2:0] ACT_FORCE_ATTACH = 3'd2;
  localparam logic [2:0] ACT_FORCE_DETACH = 3'd3;
  localparam logic [2:0] ACT_RESUME       = 3'd4;

  localparam logic REG_ATTACH_MAX = 1'b0;
  localparam logic REG_DETACH_MIN = 1'b1;

  localparam logic KIND_KEY    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // input word layout
  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  col_bits;
    logic [3:0]  column;
    logic [11:0] sample_mv;
    logic [2:0]  action;
  } in_word_t;

  // output word layout
  typedef struct packed {
    logic [4:0] pad;
    logic       link_reset;
    logic       power_enable;
    logic       attached;
    logic       pressed;
    logic [3:0] key_column;
    logic [2:0] row;
  } out_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/bdkm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module bdkm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/base_detect_and_key_matrix_diff.sv
// Detachable keyboard base controller: base detect debounce and key matrix diff.
//
// Input stream (s_*): one word per command: detect tick with a millivolt
// sample, matrix column byte, force attach, force detach or resume auto.
// Output stream (m_*): tuser is the result kind (0 key event, 1 base status),
// tlast marks the final result of a command.
// APB port: register 0 attach_max_mv at 0x0, register 1 detach_min_mv at 0x4.
//
// A tick or force command is handled on acceptance; its status word (if any) is
// presented the cycle after acceptance. A column command first reads the key
// cache, then emits one key event per changed row, one per cycle while the
// receiver takes them, lowest row first. Only one command is in flight;
// s_tready is low while a column is worked off and while the output register
// holds a word the receiver has not taken. A receiver stall simply holds the
// output word and the row sequencer. Reset restores thresholds 300/3000 mV,
// detached, auto detect on, and marks every cache entry empty (empty entries
// read as zero); detaching and a forced attach empty the cache too.
`default_nettype none
module base_detect_and_key_matrix_diff
  import bdkm_pkg::*;
#(
  parameter int unsigned NUM_COLS = NUM_COLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: action[2:0], sample_mv[14:3], column[18:15], col_bits[26:19]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,
  // m_tdata: row[2:0], key_column[6:3], pressed[7], attached[8],
  //          power_enable[9], link_reset[10]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  // m_tuser: kind[0]
  output logic             m_tuser,
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} state_t;

  state_t        state;
  logic [11:0]   attach_max_mv;
  logic [11:0]   detach_min_mv;
  logic          base_present;
  logic          debounce_pending;
  logic          auto_detect_on;
  logic [NUM_COLS-1:0] cache_valid;

  logic [CW-1:0] col_q;
  logic [3:0]    key_col_q;
  logic [7:0]    bits_q;
  logic [7:0]    diff;

  logic          out_kind;
  logic [2:0]    out_row;
  logic [3:0]    out_col;
  logic          out_pressed;
  logic          out_att;
  logic          out_lrst;
  logic          out_last;

  in_word_t      in_w;
  out_word_t     out_w;
  logic          out_free;
  logic          out_load;
  logic          s_acc;
  logic          col_in_range;
  logic [7:0]    ram_rdata;
  logic [7:0]    cached;
  logic [7:0]    diff_rd;
  logic [2:0]    low_row;
  logic [7:0]    diff_rest;
  logic          tick_hit;
  logic          cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_DETACH_MIN) ? {20'd0, detach_min_mv}
                                               : {20'd0, attach_max_mv};

  always_ff @(posedge clk) begin
    if (rst) begin
      attach_max_mv <= ATTACH_RESET_MV;
      detach_min_mv <= DETACH_RESET_MV;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ATTACH_MAX) begin
        attach_max_mv <= pwdata[11:0];
      end else begin
        detach_min_mv <= pwdata[11:0];
      end
    end
  end

  assign in_w     = in_word_t'(s_tdata);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign s_acc    = s_tvalid && s_tready;

  assign col_in_range = {2'b00, in_w.column} < 6'(NUM_COLS);

  assign tick_hit = (in_w.sample_mv >= detach_min_mv && base_present) ||
                    (in_w.sample_mv <= attach_max_mv && !base_present);

  // a new output word is loaded this cycle
  assign out_load = ((state == ST_IDLE) && s_acc &&
                     ((in_w.action == ACT_TICK && auto_detect_on && tick_hit &&
                       debounce_pending) ||
                      in_w.action == ACT_FORCE_ATTACH ||
                      in_w.action == ACT_FORCE_DETACH)) ||
                    ((state == ST_EMIT) && out_free);

  bdkm_ram #(
    .WIDTH (8),
    .DEPTH (NUM_COLS)
  ) u_cache (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (col_q),
    .wdata (bits_q),
    .raddr (CW'(in_w.column)),
    .rdata (ram_rdata)
  );

  assign cached  = cache_valid[col_q] ? ram_rdata : 8'd0;
  assign diff_rd = cached ^ bits_q;

  // lowest changed row
  always_comb begin
    low_row = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (diff[i]) begin
        low_row = 3'(i);
      end
    end
  end
  assign diff_rest = diff & (diff - 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      base_present     <= 1'b0;
      debounce_pending <= 1'b0;
      auto_detect_on   <= 1'b1;
      cache_valid      <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            unique case (in_w.action)
              ACT_TICK: begin
                if (auto_detect_on) begin
                  if (tick_hit && debounce_pending) begin
                    debounce_pending <= 1'b0;
                    base_present     <= !base_present;
                    if (base_present) begin
                      cache_valid <= '0;
                    end
                    out_kind    <= KIND_STATUS;
                    out_row     <= 3'd0;
                    out_col     <= 4'd0;
                    out_pressed <= 1'b0;
                    out_att     <= !base_present;
                    out_lrst    <= base_present;
                    out_last    <= 1'b1;
                  end else begin
                    debounce_pending <= tick_hit;
                  end
                end
              end
              ACT_COLUMN: begin
                if (col_in_range) begin
                  col_q     <= CW'(in_w.column);
                  key_col_q <= in_w.column;
                  bits_q    <= in_w.col_bits;
                  state     <= ST_READ;
                end
              end
              ACT_FORCE_ATTACH, ACT_FORCE_DETACH: begin
                auto_detect_on <= 1'b0;
                cache_valid    <= '0;
                base_present   <= (in_w.action == ACT_FORCE_ATTACH);
                out_kind       <= KIND_STATUS;
                out_row        <= 3'd0;
                out_col        <= 4'd0;
                out_pressed    <= 1'b0;
                out_att        <= (in_w.action == ACT_FORCE_ATTACH);
                out_lrst       <= 1'b1;
                out_last       <= 1'b1;
              end
              ACT_RESUME: begin
                auto_detect_on <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          // cache write-back happens this cycle through the RAM write port
          cache_valid[col_q] <= 1'b1;
          diff               <= diff_rd;
          state              <= (diff_rd == 8'd0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_kind    <= KIND_KEY;
            out_row     <= low_row;
            out_col     <= key_col_q;
            out_pressed <= bits_q[low_row];
            out_att     <= 1'b0;
            out_lrst    <= 1'b0;
            out_last    <= (diff_rest == 8'd0);
            diff        <= diff_rest;
            if (diff_rest == 8'd0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_w              = '0;
    out_w.row          = out_row;
    out_w.key_column   = out_col;
    out_w.pressed      = out_pressed;
    out_w.attached     = out_att;
    out_w.power_enable = out_att;
    out_w.link_reset   = out_lrst;
  end

  assign m_tdata = 16'(out_w);
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_STATUS) |-> m_tlast)
    else $error("status word without tlast");

  a_key_no_base_bits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_KEY) |-> (m_tdata[8] == 1'b0 && m_tdata[10] == 1'b0))
    else $error("key event carries base status bits");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("input taken while a column is in progress");

  a_detach_clears_cache: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_STATUS && $past(state) == ST_IDLE
     && !$stable(m_tvalid) && m_tdata[10]) |-> (cache_valid == '0))
    else $error("key cache not cleared on detach");
`endif

endmodule
`default_nettype wire
